### rtl/core/ccl_pkg.sv
// Shared types and constants of the circle clipped line rasterizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package ccl_pkg;

    localparam int COORD_BITS  = 13;
    localparam int COLOR_BITS  = 24;
    localparam int CFG_BITS    = 12;
    localparam int RADIUS_BITS = 6;
    localparam int DELTA_BITS  = COORD_BITS + 1;
    localparam int ERR_BITS    = COORD_BITS + 2;
    localparam int MAX_PIXELS  = 64;
    localparam int CNT_BITS    = $clog2(MAX_PIXELS);
    // walk offset from the center is bounded by the pixel budget
    localparam int OFS_BITS    = CNT_BITS + 2;
    localparam int MAG_BITS    = CNT_BITS + 1;
    localparam int SQ_BITS     = 2 * MAG_BITS;
    localparam int DIST_BITS   = SQ_BITS + 1;
    localparam int R2_BITS     = 2 * RADIUS_BITS;
    localparam int QUEUE_DEPTH = 2;

    localparam int PAYLOAD_BITS = 2 * COORD_BITS + COLOR_BITS;
    localparam int TDATA_BITS   = ((PAYLOAD_BITS + 7) / 8) * 8;
    localparam int PAD_BITS     = TDATA_BITS - PAYLOAD_BITS;

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;
    localparam int REG_IDX_BITS  = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_ORIGIN_X      = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_ORIGIN_Y      = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_CIRCLE_RADIUS = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd4;

    localparam logic [CFG_BITS-1:0]    RST_ORIGIN_X      = 12'd0;
    localparam logic [CFG_BITS-1:0]    RST_ORIGIN_Y      = 12'd0;
    localparam logic [RADIUS_BITS-1:0] RST_CIRCLE_RADIUS = 6'd63;
    localparam logic [CFG_BITS-1:0]    RST_SCREEN_WIDTH  = 12'd640;
    localparam logic [CFG_BITS-1:0]    RST_SCREEN_HEIGHT = 12'd480;

    typedef struct packed {
        logic [CFG_BITS-1:0]    origin_x;
        logic [CFG_BITS-1:0]    origin_y;
        logic [RADIUS_BITS-1:0] circle_radius;
        logic [CFG_BITS-1:0]    screen_width;
        logic [CFG_BITS-1:0]    screen_height;
    } cfg_t;

    // one classified line command, as queued between front and walker
    typedef struct packed {
        logic signed [COORD_BITS-1:0] target_x;
        logic signed [COORD_BITS-1:0] target_y;
        logic [DELTA_BITS-1:0]        delta_x;
        logic [DELTA_BITS-1:0]        delta_y;
        logic                         step_x_negative;
        logic                         step_y_negative;
        logic signed [ERR_BITS-1:0]   error_term;
        logic [COLOR_BITS-1:0]        color;
    } line_cmd_t;

endpackage

`default_nettype wire

### rtl/core/circle_clipped_line_raster.sv
// Top level of the circle clipped line rasterizer: register file, front
// stage, command queue and walker. Depends on ccl_pkg, ccl_front,
// ccl_queue and ccl_walker.
//
// Usage
//   Slave stream (s_*): one transaction is one line command, the end point
//   and color. The line always starts at the configured center.
//   Master stream (m_*): one transaction per pixel, in walk order. tuser
//   tells whether the pixel lies inside the window; tlast marks the final
//   pixel of the line. Every line yields 1 to 64 pixels: it stops at the end
//   point or before the first pixel outside the clipping circle.
//   APB port: five registers at byte offsets 0x00..0x10 (center x, center y,
//   radius, width, height). Write them only while the block is idle.
// Timing
//   With an idle walker the first pixel reaches m_tvalid through the front
//   register, the queue, the walker load and the output register. The walker
//   loads a new command only once the last line is done, then emits one pixel
//   a cycle while m_tready does not stall it, so throughput is set by the
//   walker's single step unit. The front stage and a two-deep queue accept
//   further commands while the walker is busy.
// Reset and stalls
//   Reset empties the queue, idles the walker and loads register defaults.
//   When m_tready is low the output register holds and the walker pauses;
//   commands back up through the queue until s_tready drops.
`default_nettype none

module circle_clipped_line_raster
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // APB configuration port
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [ccl_pkg::APB_ADDR_BITS-1:0]      paddr,
    input  wire logic [ccl_pkg::APB_DATA_BITS-1:0]      pwdata,
    output logic [ccl_pkg::APB_DATA_BITS-1:0]           prdata,
    output logic                                        pready,
    // line commands
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // end_x [12:0], end_y [25:13], line_color [49:26], zero pad [55:50]
    input  wire logic [ccl_pkg::TDATA_BITS-1:0]         s_tdata,
    // pixels
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // pixel_x [12:0], pixel_y [25:13], pixel_color [49:26], zero pad [55:50]
    output logic [ccl_pkg::TDATA_BITS-1:0]              m_tdata,
    // on_screen [0]
    output logic                                        m_tuser,
    // last_pixel
    output logic                                        m_tlast
);
    import ccl_pkg::*;

    cfg_t                         cfg_reg;
    cfg_t                         cfg_next;
    logic                         cfg_write;
    logic [REG_IDX_BITS-1:0]      reg_idx;

    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0]        line_color;

    logic                         front_valid;
    logic                         queue_ready;
    line_cmd_t                    front_cmd;
    logic                         queue_valid;
    logic                         queue_pop;
    line_cmd_t                    queue_cmd;

    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0]        pixel_color;

    // ---------------- register file ----------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_idx)
                REG_ORIGIN_X:      cfg_next.origin_x      = pwdata[CFG_BITS-1:0];
                REG_ORIGIN_Y:      cfg_next.origin_y      = pwdata[CFG_BITS-1:0];
                REG_CIRCLE_RADIUS: cfg_next.circle_radius = pwdata[RADIUS_BITS-1:0];
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = pwdata[CFG_BITS-1:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height = pwdata[CFG_BITS-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ORIGIN_X:      prdata = APB_DATA_BITS'(cfg_reg.origin_x);
            REG_ORIGIN_Y:      prdata = APB_DATA_BITS'(cfg_reg.origin_y);
            REG_CIRCLE_RADIUS: prdata = APB_DATA_BITS'(cfg_reg.circle_radius);
            REG_SCREEN_WIDTH:  prdata = APB_DATA_BITS'(cfg_reg.screen_width);
            REG_SCREEN_HEIGHT: prdata = APB_DATA_BITS'(cfg_reg.screen_height);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x      <= RST_ORIGIN_X;
            cfg_reg.origin_y      <= RST_ORIGIN_Y;
            cfg_reg.circle_radius <= RST_CIRCLE_RADIUS;
            cfg_reg.screen_width  <= RST_SCREEN_WIDTH;
            cfg_reg.screen_height <= RST_SCREEN_HEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------- input unpack ----------------
    assign end_x      = s_tdata[COORD_BITS-1:0];
    assign end_y      = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign line_color = s_tdata[PAYLOAD_BITS-1:2*COORD_BITS];

    // ---------------- front: classify the command ----------------
    ccl_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .end_x      (end_x),
        .end_y      (end_y),
        .line_color (line_color),
        .cmd_valid  (front_valid),
        .cmd_ready  (queue_ready),
        .cmd        (front_cmd)
    );

    // ---------------- queue between front and walker ----------------
    ccl_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (queue_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (queue_valid),
        .pop        (queue_pop),
        .pop_cmd    (queue_cmd)
    );

    // ---------------- back: walk, clip, emit ----------------
    ccl_walker u_walker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cmd_valid   (queue_valid),
        .cmd_pop     (queue_pop),
        .cmd         (queue_cmd),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .on_screen   (m_tuser),
        .last_pixel  (m_tlast)
    );

    assign m_tdata = {{PAD_BITS{1'b0}}, pixel_color, pixel_y, pixel_x};

endmodule

`default_nettype wire

### rtl/core/ccl_front.sv
// Front stage: accepts a line command and works out deltas, step signs and
// the initial error term. Depends on ccl_pkg.
`default_nettype none

module ccl_front
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire ccl_pkg::cfg_t                        cfg,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [ccl_pkg::COORD_BITS-1:0] end_x,
    input  wire logic signed [ccl_pkg::COORD_BITS-1:0] end_y,
    input  wire logic [ccl_pkg::COLOR_BITS-1:0]       line_color,
    output logic                                      cmd_valid,
    input  wire logic                                 cmd_ready,
    output ccl_pkg::line_cmd_t                        cmd
);
    import ccl_pkg::*;

    logic                         valid_reg;
    logic                         valid_next;
    line_cmd_t                    cmd_reg;
    line_cmd_t                    cmd_next;
    logic signed [DELTA_BITS-1:0] diff_x;
    logic signed [DELTA_BITS-1:0] diff_y;
    logic signed [ERR_BITS-1:0]   err_init;
    logic                         take;

    assign in_ready  = !valid_reg || cmd_ready;
    assign take      = in_valid && in_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        diff_x = DELTA_BITS'(end_x) - $signed({2'b00, cfg.origin_x});
        diff_y = DELTA_BITS'(end_y) - $signed({2'b00, cfg.origin_y});

        cmd_next                 = cmd_reg;
        cmd_next.target_x        = end_x;
        cmd_next.target_y        = end_y;
        cmd_next.delta_x         = diff_x[DELTA_BITS-1] ? DELTA_BITS'(-diff_x)
                                                        : DELTA_BITS'(diff_x);
        cmd_next.delta_y         = diff_y[DELTA_BITS-1] ? DELTA_BITS'(-diff_y)
                                                        : DELTA_BITS'(diff_y);
        // step is negative unless the target lies strictly ahead
        cmd_next.step_x_negative = !(diff_x > 0);
        cmd_next.step_y_negative = !(diff_y > 0);
        err_init = $signed({1'b0, cmd_next.delta_x}) - $signed({1'b0, cmd_next.delta_y});
        cmd_next.error_term      = err_init;
        cmd_next.color           = line_color;

        valid_next = take ? 1'b1 : (cmd_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ccl_queue.sv
// Short command queue that decouples the front stage from the walker.
// Depends on ccl_pkg.
`default_nettype none

module ccl_queue
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire ccl_pkg::line_cmd_t push_cmd,
    output logic                    pop_valid,
    input  wire logic               pop,
    output ccl_pkg::line_cmd_t      pop_cmd
);
    import ccl_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

    line_cmd_t           slots_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

endmodule

`default_nettype wire

### rtl/core/ccl_walker.sv
// Back stage: walks the Bresenham line one pixel a cycle while the output
// is not stalled, clips it to the circle and drives the output register. Depends on ccl_pkg.
`default_nettype none

module ccl_walker
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire ccl_pkg::cfg_t                        cfg,
    input  wire logic                                 cmd_valid,
    output logic                                      cmd_pop,
    input  wire ccl_pkg::line_cmd_t                   cmd,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [ccl_pkg::COORD_BITS-1:0]     pixel_x,
    output logic signed [ccl_pkg::COORD_BITS-1:0]     pixel_y,
    output logic [ccl_pkg::COLOR_BITS-1:0]            pixel_color,
    output logic                                      on_screen,
    output logic                                      last_pixel
);
    import ccl_pkg::*;

    typedef enum logic {ST_IDLE, ST_WALK} state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic signed [COORD_BITS-1:0] walk_x_reg, walk_x_next;
    logic signed [COORD_BITS-1:0] walk_y_reg, walk_y_next;
    logic signed [ERR_BITS-1:0]   err_reg, err_next;
    logic signed [OFS_BITS-1:0]   ofs_x_reg, ofs_x_next;
    logic signed [OFS_BITS-1:0]   ofs_y_reg, ofs_y_next;
    logic [CNT_BITS-1:0]          cnt_reg, cnt_next;
    logic [R2_BITS-1:0]           r2_reg, r2_next;
    line_cmd_t                    line_reg, line_next;
    logic                         out_valid_reg, out_valid_next;
    logic signed [COORD_BITS-1:0] px_reg, px_next;
    logic signed [COORD_BITS-1:0] py_reg, py_next;
    logic [COLOR_BITS-1:0]        pc_reg, pc_next;
    logic                         vis_reg, vis_next;
    logic                         last_reg, last_next;

    logic                         emit;
    logic signed [ERR_BITS:0]     e2;
    logic signed [ERR_BITS:0]     dx_s;
    logic signed [ERR_BITS:0]     dy_s;
    logic                         step_x;
    logic                         step_y;
    logic signed [ERR_BITS:0]     err_wide;
    logic signed [OFS_BITS-1:0]   nox;
    logic signed [OFS_BITS-1:0]   noy;
    logic [MAG_BITS-1:0]          mag_x;
    logic [MAG_BITS-1:0]          mag_y;
    logic [SQ_BITS-1:0]           sq_x;
    logic [SQ_BITS-1:0]           sq_y;
    logic [DIST_BITS-1:0]         rad_sq;
    logic                         outside;
    logic                         at_target;
    logic                         budget_done;
    logic                         vis;
    logic                         last;

    assign emit        = (state_reg == ST_WALK) && (!out_valid_reg || out_ready);
    assign cmd_pop     = (state_reg == ST_IDLE) && cmd_valid;
    assign out_valid   = out_valid_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign pixel_color = pc_reg;
    assign on_screen   = vis_reg;
    assign last_pixel  = last_reg;

    // next pixel of the walk and its squared distance from the center
    always_comb
    begin
        e2     = {err_reg, 1'b0};
        dx_s   = $signed({2'b00, line_reg.delta_x});
        dy_s   = $signed({2'b00, line_reg.delta_y});
        step_x = (e2 > -dy_s);
        step_y = (e2 < dx_s);

        err_wide = (ERR_BITS + 1)'(err_reg);
        if (step_x)
        begin
            err_wide = err_wide - dy_s;
        end
        if (step_y)
        begin
            err_wide = err_wide + dx_s;
        end

        nox = ofs_x_reg;
        noy = ofs_y_reg;
        if (step_x)
        begin
            nox = line_reg.step_x_negative ? ofs_x_reg - 1'b1 : ofs_x_reg + 1'b1;
        end
        if (step_y)
        begin
            noy = line_reg.step_y_negative ? ofs_y_reg - 1'b1 : ofs_y_reg + 1'b1;
        end

        mag_x   = nox[OFS_BITS-1] ? MAG_BITS'(-nox) : MAG_BITS'(nox);
        mag_y   = noy[OFS_BITS-1] ? MAG_BITS'(-noy) : MAG_BITS'(noy);
        sq_x    = mag_x * mag_x;
        sq_y    = mag_y * mag_y;
        rad_sq  = {1'b0, sq_x} + {1'b0, sq_y};
        outside = (rad_sq > DIST_BITS'(r2_reg));

        at_target   = (walk_x_reg == line_reg.target_x) && (walk_y_reg == line_reg.target_y);
        budget_done = (cnt_reg == CNT_BITS'(MAX_PIXELS - 1));
        last        = at_target || budget_done || outside;

        vis = !walk_x_reg[COORD_BITS-1] && !walk_y_reg[COORD_BITS-1]
           && (CFG_BITS'(walk_x_reg) < cfg.screen_width)
           && (CFG_BITS'(walk_y_reg) < cfg.screen_height)
           && (walk_x_reg[COORD_BITS-2:0] >> CFG_BITS) == '0
           && (walk_y_reg[COORD_BITS-2:0] >> CFG_BITS) == '0;
    end

    always_comb
    begin
        state_next     = state_reg;
        walk_x_next    = walk_x_reg;
        walk_y_next    = walk_y_reg;
        err_next       = err_reg;
        ofs_x_next     = ofs_x_reg;
        ofs_y_next     = ofs_y_reg;
        cnt_next       = cnt_reg;
        r2_next        = r2_reg;
        line_next      = line_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pc_next        = pc_reg;
        vis_next       = vis_reg;
        last_next      = last_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    line_next   = cmd;
                    walk_x_next = $signed({1'b0, cfg.origin_x});
                    walk_y_next = $signed({1'b0, cfg.origin_y});
                    err_next    = cmd.error_term;
                    ofs_x_next  = '0;
                    ofs_y_next  = '0;
                    cnt_next    = '0;
                    r2_next     = cfg.circle_radius * cfg.circle_radius;
                    state_next  = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    px_next        = walk_x_reg;
                    py_next        = walk_y_reg;
                    pc_next        = line_reg.color;
                    vis_next       = vis;
                    last_next      = last;
                    cnt_next       = cnt_reg + 1'b1;
                    err_next       = ERR_BITS'(err_wide);
                    ofs_x_next     = nox;
                    ofs_y_next     = noy;
                    if (step_x)
                    begin
                        walk_x_next = line_reg.step_x_negative ? walk_x_reg - 1'b1
                                                               : walk_x_reg + 1'b1;
                    end
                    if (step_y)
                    begin
                        walk_y_next = line_reg.step_y_negative ? walk_y_reg - 1'b1
                                                               : walk_y_reg + 1'b1;
                    end
                    if (last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            walk_x_reg    <= '0;
            walk_y_reg    <= '0;
            err_reg       <= '0;
            ofs_x_reg     <= '0;
            ofs_y_reg     <= '0;
            r2_reg        <= '0;
            line_reg      <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            pc_reg        <= '0;
            vis_reg       <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            walk_x_reg    <= walk_x_next;
            walk_y_reg    <= walk_y_next;
            err_reg       <= err_next;
            ofs_x_reg     <= ofs_x_next;
            ofs_y_reg     <= ofs_y_next;
            r2_reg        <= r2_next;
            line_reg      <= line_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            pc_reg        <= pc_next;
            vis_reg       <= vis_next;
            last_reg      <= last_next;
        end
    end

    a_budget_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && budget_done) |=> (last_reg && state_reg == ST_IDLE))
        else $error("pixel budget reached without closing the line");

    a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last) |=> (state_reg == ST_IDLE))
        else $error("walk continued past the last pixel");

    a_ofs_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |->
            (ofs_x_reg < OFS_BITS'(MAX_PIXELS) && ofs_x_reg > -OFS_BITS'(MAX_PIXELS)))
        else $error("walk offset beyond the pixel budget");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg == ST_WALK))
        else $error("command popped without starting a walk");

endmodule

`default_nettype wire

### dv/tb_circle_clipped_line_raster.sv
`timescale 1ns / 100ps
// Self-checking testbench for circle_clipped_line_raster: directed and random line
// commands, APB register setup, stream back-pressure. Depends on ccl_pkg and the RTL.

module tb_circle_clipped_line_raster;

    import ccl_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int DRAIN_SETTLE  = 10;
    localparam int END_SETTLE    = 20;
    localparam int REPORT_LIMIT  = 10;
    localparam int HOLD_OFF_LEN  = 500;

    // register indexes with no register behind them
    localparam logic [REG_IDX_BITS-1:0] REG_UNMAPPED_A = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_UNMAPPED_B = 3'd6;
    localparam logic [REG_IDX_BITS-1:0] REG_UNMAPPED_C = 3'd7;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [COLOR_BITS-1:0]        color;
        logic                         on_screen;
        logic                         last;
    } pixel_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0]  paddr = '0;
    logic [APB_DATA_BITS-1:0]  pwdata = '0;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    // end_x [12:0], end_y [25:13], line_color [49:26], zero pad [55:50]
    logic [TDATA_BITS-1:0]     s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    // pixel_x [12:0], pixel_y [25:13], pixel_color [49:26], zero pad [55:50]
    logic [TDATA_BITS-1:0]     m_tdata;
    // on_screen [0]
    logic                      m_tuser;
    logic                      m_tlast;

    // mirror of the register file
    logic [CFG_BITS-1:0]       cfg_origin_x = RST_ORIGIN_X;
    logic [CFG_BITS-1:0]       cfg_origin_y = RST_ORIGIN_Y;
    logic [RADIUS_BITS-1:0]    cfg_radius   = RST_CIRCLE_RADIUS;
    logic [CFG_BITS-1:0]       cfg_width    = RST_SCREEN_WIDTH;
    logic [CFG_BITS-1:0]       cfg_height   = RST_SCREEN_HEIGHT;

    pixel_t line_pixels[$];    // pixels still owed by the block, oldest first

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off_left  = 0;
    int lines_sent     = 0;
    int pixels_checked = 0;
    int reg_writes     = 0;
    int mismatches     = 0;
    int cycle_count    = 0;

    circle_clipped_line_raster uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #CLK_HALF clk = ~clk;

    // Bresenham walk from the center toward the end point, clipped by the
    // circle and by the 64 pixel budget; queues every pixel the line owes.
    function automatic void rasterize_line(input logic signed [COORD_BITS-1:0] end_x,
                                           input logic signed [COORD_BITS-1:0] end_y,
                                           input logic [COLOR_BITS-1:0] color);
        int cx, cy, tx, ty, dx, dy, sx, sy, err, e2, px, py, ox, oy, r2, count;
        bit done;
        pixel_t pix;
        cx = int'(cfg_origin_x);
        cy = int'(cfg_origin_y);
        tx = int'(end_x);
        ty = int'(end_y);
        r2 = int'(cfg_radius) * int'(cfg_radius);
        dx = (tx > cx) ? tx - cx : cx - tx;
        dy = (ty > cy) ? ty - cy : cy - ty;
        sx = (cx < tx) ? 1 : -1;
        sy = (cy < ty) ? 1 : -1;
        err = dx - dy;
        px = cx;
        py = cy;
        count = 0;
        done = 1'b0;
        while (!done) begin
            pix.x = px[COORD_BITS-1:0];
            pix.y = py[COORD_BITS-1:0];
            pix.color = color;
            pix.on_screen = (px >= 0) && (px < int'(cfg_width)) &&
                            (py >= 0) && (py < int'(cfg_height));
            count++;
            if ((px == tx && py == ty) || count >= MAX_PIXELS) begin
                done = 1'b1;
            end
            else begin
                e2 = 2 * err;
                if (e2 > -dy) begin
                    err -= dy;
                    px += sx;
                end
                if (e2 < dx) begin
                    err += dx;
                    py += sy;
                end
                ox = px - cx;
                oy = py - cy;
                // the next pixel leaves the circle: the walk ends here
                if (ox * ox + oy * oy > r2) begin
                    done = 1'b1;
                end
            end
            pix.last = done;
            line_pixels.push_back(pix);
        end
    endfunction

    // APB write: setup phase, then access phase until pready, then back to idle
    task automatic write_register(input logic [REG_IDX_BITS-1:0] index,
                                  input logic [APB_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_ORIGIN_X:      cfg_origin_x = value[CFG_BITS-1:0];
            REG_ORIGIN_Y:      cfg_origin_y = value[CFG_BITS-1:0];
            REG_CIRCLE_RADIUS: cfg_radius   = value[RADIUS_BITS-1:0];
            REG_SCREEN_WIDTH:  cfg_width    = value[CFG_BITS-1:0];
            REG_SCREEN_HEIGHT: cfg_height   = value[CFG_BITS-1:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic write_config(input int cx, input int cy, input int radius,
                                input int width, input int height);
        write_register(REG_ORIGIN_X, ($urandom << CFG_BITS) | cx);
        write_register(REG_ORIGIN_Y, ($urandom << CFG_BITS) | cy);
        write_register(REG_CIRCLE_RADIUS, ($urandom << RADIUS_BITS) | radius);
        write_register(REG_SCREEN_WIDTH, ($urandom << CFG_BITS) | width);
        write_register(REG_SCREEN_HEIGHT, ($urandom << CFG_BITS) | height);
    endtask

    // One line command transaction; valid stays up across back-to-back commands.
    task automatic send_line(input int end_x, input int end_y,
                             input logic [COLOR_BITS-1:0] color);
        logic signed [COORD_BITS-1:0] ex;
        logic signed [COORD_BITS-1:0] ey;
        ex = COORD_BITS'(end_x);
        ey = COORD_BITS'(end_y);
        s_tdata  <= {{PAD_BITS{1'b0}}, color, ey, ex};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        rasterize_line(ex, ey, color);
        lines_sent++;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stop sending and wait for every owed pixel, then let the walker settle.
    task automatic drain_pixels();
        s_tvalid <= 1'b0;
        while (line_pixels.size() != 0) @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
    endtask

    function automatic int pick_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 70);
            1:       return $urandom_range(4025, 4095);
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    function automatic int near_bound(input int base);
        int v;
        v = base + int'($urandom_range(0, 80)) - 40;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v;
    endfunction

    task automatic randomize_config();
        int cx, cy, radius, width, height;
        cx = pick_coord();
        cy = pick_coord();
        radius = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 63);
        // half the time put the window edge close to the center so lines cross it
        width  = $urandom_range(0, 1) ? near_bound(cx) : $urandom_range(0, 4095);
        height = $urandom_range(0, 1) ? near_bound(cy) : $urandom_range(0, 4095);
        write_config(cx, cy, radius, width, height);
    endtask

    // Mostly end points near the circle so lines run to their end or just past
    // the rim; the rest anywhere in the signed coordinate range.
    task automatic send_random_line();
        int reach, ex, ey;
        reach = int'(cfg_radius) + 3;
        if ($urandom_range(0, 3) != 0) begin
            ex = int'(cfg_origin_x) + int'($urandom_range(0, 2 * reach)) - reach;
            ey = int'(cfg_origin_y) + int'($urandom_range(0, 2 * reach)) - reach;
        end
        else begin
            ex = int'($urandom_range(0, 8191)) - 4096;
            ey = int'($urandom_range(0, 8191)) - 4096;
        end
        send_line(ex, ey, COLOR_BITS'($urandom));
    endtask

    // Defaults after reset: center at the origin, radius 63, 640x480 window.
    task automatic test_reset_values();
        send_line(0, 0, 24'h000000);
        send_line(5, 3, 24'hFFFFFF);
        send_line(-7, -2, 24'hA5A5A5);
        send_line(4095, 4095, 24'h5A5A5A);
        send_line(4095, 0, 24'h123456);
        send_line(-4096, -4096, 24'hFEDCBA);
        drain_pixels();
    endtask

    task automatic test_radius_extremes();
        write_config(2000, 100, 0, 4095, 4095);
        send_line(2010, 100, 24'h0F0F0F);      // zero radius: center only
        send_line(2000, 100, 24'hF0F0F0);      // end point on the center
        drain_pixels();
        write_register(REG_CIRCLE_RADIUS, 1);
        send_line(2005, 105, 24'h00FF00);
        drain_pixels();
        write_register(REG_CIRCLE_RADIUS, 63);
        send_line(2063, 100, 24'hFF0000);      // ends on the rim at the pixel budget
        send_line(2000, -4096, 24'h0000FF);    // clipped straight down
        send_line(1937, 163, 24'h808080);
        drain_pixels();
    endtask

    task automatic test_window_edges();
        write_config(4095, 4095, 10, 4095, 4095);
        send_line(4095, 4095, 24'h111111);     // column 4095 is already off screen
        send_line(4085, 4090, 24'h222222);
        send_line(-4096, -4096, 24'h333333);
        drain_pixels();
        write_config(0, 0, 10, 0, 0);          // empty window
        send_line(5, -5, 24'h444444);
        drain_pixels();
        write_register(REG_SCREEN_WIDTH, 1);
        write_register(REG_SCREEN_HEIGHT, 1);
        send_line(3, 3, 24'h555555);           // only the origin is visible
        drain_pixels();
    endtask

    // Writes to indexes past the register file must change nothing.
    task automatic test_unmapped_registers();
        write_register(REG_UNMAPPED_A, $urandom);
        write_register(REG_UNMAPPED_B, $urandom);
        write_register(REG_UNMAPPED_C, $urandom);
        send_line(-3, 4, 24'h666666);
        send_line(2, 2, 24'h777777);
        drain_pixels();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int item_count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int setting = 0; setting < 2; setting++) begin
            randomize_config();
            for (int i = 0; i < item_count / 2; i++) begin
                send_random_line();
            end
            drain_pixels();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Receiver holds off long enough for the front stage and queue to fill.
    task automatic test_backpressure();
        write_config(1000, 1000, 20, 1010, 990);
        hold_off_left = HOLD_OFF_LEN;
        for (int i = 0; i < 12; i++) begin
            send_random_line();
        end
        drain_pixels();
    endtask

    // receiver: random stalls, plus the long hold-off when requested
    always @(posedge clk) begin
        if (hold_off_left > 0) begin
            hold_off_left = hold_off_left - 1;
            m_tready <= 1'b0;
        end
        else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // pixel checker: every accepted transaction against the oldest owed pixel
    always @(posedge clk) begin : check_pixel
        pixel_t got;
        pixel_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got.x         = m_tdata[COORD_BITS-1:0];
            got.y         = m_tdata[2*COORD_BITS-1:COORD_BITS];
            got.color     = m_tdata[2*COORD_BITS+COLOR_BITS-1:2*COORD_BITS];
            got.on_screen = m_tuser;
            got.last      = m_tlast;
            if (line_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("pixel %0d: unexpected transaction x=%0d y=%0d color=%06h on=%0b last=%0b",
                             pixels_checked, got.x, got.y, got.color, got.on_screen, got.last);
                end
            end
            else begin
                want = line_pixels.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("pixel %0d: expected x=%0d y=%0d color=%06h on=%0b last=%0b",
                                 pixels_checked, want.x, want.y, want.color, want.on_screen,
                                 want.last);
                        $display("pixel %0d:      got x=%0d y=%0d color=%06h on=%0b last=%0b",
                                 pixels_checked, got.x, got.y, got.color, got.on_screen,
                                 got.last);
                    end
                end
            end
            pixels_checked++;
        end
    end

    // run limit
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d pixels still owed", cycle_count,
                 line_pixels.size());
        $display("circle_clipped_line_raster regression: fail");
        $finish;
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_radius_extremes();
        test_window_edges();
        test_unmapped_registers();
        test_random_phase(0, 0, 60);
        test_random_phase(82, 0, 60);
        test_random_phase(0, 82, 60);
        test_random_phase(15, 15, 60);
        test_backpressure();
        repeat (END_SETTLE) @(posedge clk);
        $display("covered %0d line commands, %0d pixels, %0d register writes in %0d cycles",
                 lines_sent, pixels_checked, reg_writes, cycle_count);
        $display("mismatching pixels: %0d", mismatches);
        if (mismatches == 0 && line_pixels.size() == 0) begin
            $display("circle_clipped_line_raster regression: pass");
        end
        else begin
            $display("circle_clipped_line_raster regression: fail");
        end
        $finish;
    end

endmodule
